// ===== sv/packet_fifo_dedup_range_count_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet FIFO block
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef PACKET_FIFO_DEDUP_RANGE_COUNT_TOP_ASSERT_SVH
`define PACKET_FIFO_DEDUP_RANGE_COUNT_TOP_ASSERT_SVH

// same-cycle implication
`define PFDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfdc assertion failed");

// next-cycle implication
`define PFDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfdc assertion failed");

`endif

// ===== sv/pfdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_pkg
// Types and constants shared by the packet FIFO with duplicate check and
// range count.
// ----------------------------------------------------------------------------
package pfdc_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 18;
  localparam int TIME_W = 30;
  localparam int CAP_W  = 9;
  localparam int CNT_W  = 9;

  // request codes
  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_FWD  = 2'd1;
  localparam logic [1:0] REQ_CNT  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FWD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   src;
    logic [ID_W-1:0]   dst;
    logic [TIME_W-1:0] ts;
  } entry_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   source;
    logic [ID_W-1:0]   destination;
    logic [TIME_W-1:0] timestamp;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } in_req_t;

  typedef struct packed {
    logic              accepted;
    logic              packet_valid;
    logic [ID_W-1:0]   out_source;
    logic [ID_W-1:0]   out_destination;
    logic [TIME_W-1:0] out_timestamp;
    logic [CNT_W-1:0]  match_count;
  } out_res_t;

endpackage

// ===== sv/pfdc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_ram
// Packet store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfdc_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pfdc_pkg::ADDR_W-1:0] waddr,
  input  pfdc_pkg::entry_t           wdata,
  input  logic                       re,
  input  logic [pfdc_pkg::ADDR_W-1:0] raddr,
  output pfdc_pkg::entry_t           rdata
);

  pfdc_pkg::entry_t mem [pfdc_pkg::DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/packet_fifo_dedup_range_count_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_fifo_dedup_range_count_top
// Bounded packet FIFO with duplicate rejection on add, pop on forward and a
// destination / time-window count over all stored packets.
// ----------------------------------------------------------------------------
// One request at a time. A request is taken when start is high and busy is
// low; its result appears on out_res for exactly one cycle with out_strobe
// high, in the first cycle that busy is low again, and is not held: the
// receiver must take it then. An add or count walks every stored packet
// through the single read port of the packet store, one per cycle, so busy
// stays high until every stored packet has been read. A forward reads only
// the head packet and an unused request code reads none. capacity may be
// written through cfg_we / cfg_data only while no request is in flight; 0
// acts as 1 and values above 256 act as 256.
// ----------------------------------------------------------------------------
module packet_fifo_dedup_range_count_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  pfdc_pkg::in_req_t          in_req,
  output logic                       out_strobe,
  output pfdc_pkg::out_res_t         out_res,
  input  logic                       cfg_we,
  input  logic [pfdc_pkg::CAP_W-1:0] cfg_data
);

  pfdc_pkg::state_t   state_r, state_nxt;
  pfdc_pkg::in_req_t  req_r, req_nxt;
  logic [pfdc_pkg::OCC_W-1:0]  idx_r, idx_nxt;
  logic [pfdc_pkg::ADDR_W-1:0] head_r, head_nxt;
  logic [pfdc_pkg::ADDR_W-1:0] tail_r, tail_nxt;
  logic [pfdc_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic [pfdc_pkg::CAP_W-1:0]  cap_r;
  logic                        dup_r, dup_nxt;
  logic [pfdc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic                        out_strobe_r, out_strobe_nxt;
  pfdc_pkg::out_res_t          out_res_r, out_res_nxt;

  logic                        ram_we;
  logic                        ram_re;
  logic [pfdc_pkg::ADDR_W-1:0] ram_raddr;
  pfdc_pkg::entry_t            ram_wdata;
  pfdc_pkg::entry_t            ram_rdata;

  logic [pfdc_pkg::OCC_W-1:0]  eff_cap;
  logic                        hit_dup;
  logic                        hit_cnt;

  pfdc_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = pfdc_pkg::OCC_W'(1);
    end else if ((pfdc_pkg::CAP_W + 1)'(cap_r) > (pfdc_pkg::CAP_W + 1)'(pfdc_pkg::DEPTH)) begin
      eff_cap = pfdc_pkg::OCC_W'(pfdc_pkg::DEPTH);
    end else begin
      eff_cap = pfdc_pkg::OCC_W'(cap_r);
    end
  end

  // compare the entry read last cycle against the request
  assign hit_dup = (ram_rdata.src == req_r.source) && (ram_rdata.dst == req_r.destination)
                && (ram_rdata.ts == req_r.timestamp);
  assign hit_cnt = (ram_rdata.dst == req_r.destination) && (ram_rdata.ts >= req_r.start_time)
                && (ram_rdata.ts <= req_r.end_time);

  assign ram_wdata.src = req_r.source;
  assign ram_wdata.dst = req_r.destination;
  assign ram_wdata.ts  = req_r.timestamp;

  // next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    idx_nxt        = idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    dup_nxt        = dup_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = head_r + idx_r[pfdc_pkg::ADDR_W-1:0];

    // accumulate scan results
    if (rd_vld_r) begin
      if (req_r.req_type == pfdc_pkg::REQ_ADD && hit_dup) begin
        dup_nxt = 1'b1;
      end
      if (req_r.req_type == pfdc_pkg::REQ_CNT && hit_cnt && cnt_r != '1) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    case (state_r)
      pfdc_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          idx_nxt = '0;
          dup_nxt = 1'b0;
          cnt_nxt = '0;
          if (in_req.req_type == pfdc_pkg::REQ_FWD) begin
            state_nxt = pfdc_pkg::ST_FWD;
          end else if (in_req.req_type == pfdc_pkg::REQ_ADD ||
                       in_req.req_type == pfdc_pkg::REQ_CNT) begin
            state_nxt = pfdc_pkg::ST_SCAN;
          end else begin
            state_nxt = pfdc_pkg::ST_DONE;
          end
        end
      end
      pfdc_pkg::ST_SCAN: begin
        // one stored entry per cycle, oldest first
        if (idx_r < occ_r) begin
          ram_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          idx_nxt    = idx_r + 1'b1;
        end else begin
          state_nxt = pfdc_pkg::ST_DONE;
        end
      end
      pfdc_pkg::ST_FWD: begin
        // fetch the head entry
        ram_re    = 1'b1;
        ram_raddr = head_r;
        state_nxt = pfdc_pkg::ST_DONE;
      end
      pfdc_pkg::ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_res_nxt    = '0;
        case (req_r.req_type)
          pfdc_pkg::REQ_ADD: begin
            if (!dup_r) begin
              out_res_nxt.accepted = 1'b1;
              ram_we   = 1'b1;
              tail_nxt = tail_r + 1'b1;
              // full: evict oldest, occupancy unchanged
              if (occ_r >= eff_cap && occ_r != '0) begin
                head_nxt = head_r + 1'b1;
              end else begin
                occ_nxt = occ_r + 1'b1;
              end
            end
          end
          pfdc_pkg::REQ_FWD: begin
            if (occ_r != '0) begin
              out_res_nxt.packet_valid    = 1'b1;
              out_res_nxt.out_source      = ram_rdata.src;
              out_res_nxt.out_destination = ram_rdata.dst;
              out_res_nxt.out_timestamp   = ram_rdata.ts;
              head_nxt = head_r + 1'b1;
              occ_nxt  = occ_r - 1'b1;
            end
          end
          pfdc_pkg::REQ_CNT: begin
            out_res_nxt.match_count = cnt_r;
          end
          default: begin
          end
        endcase
        state_nxt = pfdc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pfdc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pfdc_pkg::ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      cap_r        <= pfdc_pkg::CAP_W'(pfdc_pkg::DEPTH);
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      occ_r        <= occ_nxt;
      idx_r        <= idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    dup_r     <= dup_nxt;
    cnt_r     <= cnt_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = (state_r != pfdc_pkg::ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ===== sv/pfdc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfdc_checker
// Port-level checks on the packet FIFO request / result behaviour.
// ----------------------------------------------------------------------------
`include "packet_fifo_dedup_range_count_top_assert.svh"

module pfdc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input pfdc_pkg::out_res_t out_res
);

  // an accepted request always occupies the block
  `PFDC_ASSERT_NEXT(a_start_busy, start && !busy, busy)

  // one result per request, never back to back
  `PFDC_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)

  // add and forward results are exclusive
  `PFDC_ASSERT_NOW(a_kind_excl, out_strobe, !(out_res.accepted && out_res.packet_valid))

  // no forwarded packet means zero payload
  `PFDC_ASSERT_NOW(a_empty_zero, out_strobe && !out_res.packet_valid,
    out_res.out_source == '0 && out_res.out_destination == '0 &&
    out_res.out_timestamp == '0)

  // an add result carries no count
  `PFDC_ASSERT_NOW(a_add_nocount, out_strobe && out_res.accepted, out_res.match_count == '0)

endmodule

bind packet_fifo_dedup_range_count_top pfdc_checker u_pfdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
